### sv/lfo_tremolo_gain_assert.svh
// Assertion macros shared by the tremolo gain RTL.
`ifndef LFO_TREMOLO_GAIN_ASSERT_SVH
`define LFO_TREMOLO_GAIN_ASSERT_SVH
`ifndef SYNTHESIS
`define LTG_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("tremolo gain: assertion failed");
`define LTG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tremolo gain: assertion failed");
`else
`define LTG_ASSERT(lbl, expr)
`define LTG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/ltg_pkg.sv
// Package: widths, register indexes, shapes and the quarter-wave sine table.
`default_nettype none
package ltg_pkg;

    localparam int PHASE_BITS  = 24;
    localparam int SAMPLE_BITS = 24;
    localparam int SINE_DEPTH  = 256;

    localparam int SINE_IDX_W = $clog2(SINE_DEPTH + 1);
    localparam int TAB_W      = 15;
    localparam int WAVE_W     = 16;
    localparam int MOD_W      = 17;

    localparam int MUL_A_W = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int TDATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP   = 3'd0,
        REG_SMOOTH_COEFF = 3'd1,
        REG_MOD_DEPTH    = 3'd2,
        REG_MOD_OFFSET   = 3'd3,
        REG_WAVE_SHAPE   = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_TRIANGLE = 2'd1,
        SHAPE_SQUARE   = 2'd2
    } wave_shape_t;

    localparam logic [23:0] PHASE_STEP_RESET   = 24'd699;
    localparam logic [15:0] SMOOTH_COEFF_RESET = 16'd65533;
    localparam logic [15:0] MOD_DEPTH_RESET    = 16'd32768;
    localparam logic [15:0] MOD_OFFSET_RESET   = 16'd0;

    typedef logic [TAB_W-1:0] sine_tab_t [SINE_DEPTH+1];

    // round(32767*sin(pi/2*k/D)) from a fixed-point Taylor series
    function automatic logic [TAB_W-1:0] quarter_sine(int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] s;
        logic signed [63:0] r;
        x    = (64'(k) * 64'd1686629713) / SINE_DEPTH;
        x2   = (x * x) >> 30;
        s    = $signed(x);
        term = ((x * x2) >> 30) / 64'd6;
        s    = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        s    = s + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        s    = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        s    = s + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        s    = s - $signed(term);
        if (s < 0) s = 0;
        r = (s * 64'sd32767 + 64'sd536870912) >>> 30;
        if (r > 64'sd32767) r = 64'sd32767;
        return TAB_W'(r);
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t t;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            t[k] = quarter_sine(k);
        end
        return t;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

### sv/ltg_wave.sv
// Waveform generator: sine, triangle or square from the oscillator phase.
`default_nettype none
module ltg_wave (
    input  wire logic [ltg_pkg::PHASE_BITS-1:0] phase,
    input  wire logic [1:0]                     shape,
    output logic signed [ltg_pkg::WAVE_W-1:0]   wave
);
    localparam int PB     = ltg_pkg::PHASE_BITS;
    localparam int IW     = ltg_pkg::SINE_IDX_W;
    localparam int QD_W   = PB - 2 + IW;
    localparam int TRI_SR = (PB >= 17) ? PB - 17 : 0;
    localparam int TRI_SL = (PB < 17) ? 17 - PB : 0;

    logic [1:0]                      quad;
    logic [QD_W-1:0]                 qd;
    logic [IW-1:0]                   idx;
    logic [IW-1:0]                   sidx;
    logic [ltg_pkg::TAB_W-1:0]       tab;
    logic signed [ltg_pkg::WAVE_W-1:0] sine;
    logic signed [ltg_pkg::WAVE_W-1:0] tri_w;
    logic signed [ltg_pkg::WAVE_W-1:0] sqr_w;
    logic [16:0]                     tri_u;
    logic signed [17:0]              tri_dn;

    always_comb begin
        quad = phase[PB-1 -: 2];
        qd   = QD_W'(phase[PB-3:0]) * QD_W'(ltg_pkg::SINE_DEPTH);
        idx  = IW'(qd >> (PB - 2));
        sidx = quad[0] ? (IW'(ltg_pkg::SINE_DEPTH) - idx) : idx;
        tab  = ltg_pkg::SINE_TAB[sidx];
        sine = quad[1] ? -$signed({1'b0, tab}) : $signed({1'b0, tab});

        tri_u  = (PB >= 17) ? 17'(phase >> TRI_SR) : (17'(phase) << TRI_SL);
        tri_dn = 18'sd98304 - $signed({1'b0, tri_u});
        if (!tri_u[16]) begin
            tri_w = $signed({~tri_u[15], tri_u[14:0]});
        end else if (tri_dn > 18'sd32767) begin
            tri_w = 16'sd32767;
        end else begin
            tri_w = 16'(tri_dn);
        end

        sqr_w = quad[1] ? -16'sd32768 : 16'sd32767;

        case (shape)
            ltg_pkg::SHAPE_TRIANGLE: wave = tri_w;
            ltg_pkg::SHAPE_SQUARE:   wave = sqr_w;
            default:                 wave = sine;
        endcase
    end
endmodule
`default_nettype wire

### sv/ltg_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none
module ltg_mul (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic signed [ltg_pkg::MUL_A_W-1:0]  a,
    input  wire logic signed [ltg_pkg::MUL_B_W-1:0]  b,
    output logic signed [ltg_pkg::PROD_W-1:0]        prod
);
    logic signed [ltg_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= ltg_pkg::PROD_W'(a) * ltg_pkg::PROD_W'(b);
        end
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

### sv/lfo_tremolo_gain.sv
// Stereo tremolo: LFO-driven gain applied to each sample pair.
//
// Input stream s_*: one stereo pair per request, left in the low tdata bits.
// Output stream m_*: the pair multiplied by 1 + clamp(offset + depth*lfo),
// rounded and saturated to the sample width, same packing.
// Config port: cfg_we/cfg_index/cfg_data write one register per clock;
// write only while no sample is in flight.
// A pair steps through MCM, MCW, SMOOTH, MDS, GAIN, ML, MR and OUT, and no
// new pair is taken before it is done: s_tready is high only while the
// sequencer is idle, since every product goes through the single registered
// multiplier (five multiplies per pair plus smoother add and gain clamp steps).
// The output register holds a finished pair; the next pair is accepted and
// computed meanwhile and waits in its last step until m_tready frees the
// output register.
// Reset (aresetn low, synchronous): registers return to their defaults,
// phase and smoother state clear, both channels go idle.
`default_nettype none
`include "lfo_tremolo_gain_assert.svh"
module lfo_tremolo_gain (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [ltg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ltg_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ltg_pkg::TDATA_W-1:0]       s_tdata,  // left_in, right_in
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ltg_pkg::TDATA_W-1:0]            m_tdata   // left_out, right_out
);
    localparam int PB   = ltg_pkg::PHASE_BITS;
    localparam int SB   = ltg_pkg::SAMPLE_BITS;
    localparam int MA   = ltg_pkg::MUL_A_W;
    localparam int MB   = ltg_pkg::MUL_B_W;
    localparam int PW   = ltg_pkg::PROD_W;
    localparam int ACCW = 36;
    localparam int WETW = 35;
    localparam int YW   = PW - 30;

    localparam logic signed [WETW-1:0] ONE_Q30 = 35'sd1073741824;
    localparam logic signed [YW-1:0] SAT_HI = YW'($signed({1'b0, {(SB-1){1'b1}}}));
    localparam logic signed [YW-1:0] SAT_LO = YW'($signed({1'b1, {(SB-1){1'b0}}}));

    typedef enum logic [3:0] {
        ST_IDLE, ST_MCM, ST_MCW, ST_SMOOTH, ST_MDS, ST_GAIN, ST_ML, ST_MR, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [PB-1:0]               phase_step_reg, phase_step_next;
    logic [15:0]                 smooth_coeff_reg, smooth_coeff_next;
    logic [15:0]                 mod_depth_reg, mod_depth_next;
    logic signed [15:0]          mod_offset_reg, mod_offset_next;
    logic [1:0]                  wave_shape_reg, wave_shape_next;

    logic [PB-1:0]               phase_acc_reg, phase_acc_next;
    logic signed [ltg_pkg::MOD_W-1:0] smoothed_reg, smoothed_next;

    logic signed [SB-1:0]        left_reg, left_next;
    logic signed [SB-1:0]        right_reg, right_next;
    logic signed [ltg_pkg::WAVE_W-1:0] w_reg, w_next;
    logic signed [ACCW-1:0]      acc_reg, acc_next;
    logic signed [MB-1:0]        gain_reg, gain_next;
    logic signed [SB-1:0]        left_res_reg, left_res_next;
    logic signed [SB-1:0]        left_out_reg, left_out_next;
    logic signed [SB-1:0]        right_out_reg, right_out_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    logic signed [ltg_pkg::WAVE_W-1:0] wave;
    logic                        mul_en;
    logic signed [MA-1:0]        mul_a;
    logic signed [MB-1:0]        mul_b;
    logic signed [PW-1:0]        prod;

    logic [16:0]                 depth;
    logic signed [ACCW-1:0]      acc_sum;
    logic signed [WETW-1:0]      wet;
    logic signed [WETW-1:0]      wet_cl;
    logic signed [PW-1:0]        rnd;
    logic signed [YW-1:0]        y;
    logic signed [SB-1:0]        sat_val;

    ltg_wave u_wave (
        .phase (phase_acc_reg),
        .shape (wave_shape_reg),
        .wave  (wave)
    );

    ltg_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb begin
        depth   = (mod_depth_reg > 16'd32768) ? 17'd32768 : 17'(mod_depth_reg);
        acc_sum = acc_reg + ACCW'(prod);
        wet     = (WETW'(mod_offset_reg) <<< 15) + WETW'(prod);
        if (wet > ONE_Q30) begin
            wet_cl = ONE_Q30;
        end else if (wet < -ONE_Q30) begin
            wet_cl = -ONE_Q30;
        end else begin
            wet_cl = wet;
        end
        rnd = prod + PW'(36'sd536870912);
        y   = YW'(rnd >>> 30);
        if (y > SAT_HI) begin
            sat_val = SB'(SAT_HI);
        end else if (y < SAT_LO) begin
            sat_val = SB'(SAT_LO);
        end else begin
            sat_val = SB'(y);
        end
    end

    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_MCM: begin
                mul_en = 1'b1;
                mul_a  = $signed(MA'(smooth_coeff_reg));
                mul_b  = MB'(smoothed_reg);
            end
            ST_MCW: begin
                mul_en = 1'b1;
                mul_a  = $signed(MA'(17'd65536 - 17'(smooth_coeff_reg)));
                mul_b  = MB'(w_reg);
            end
            ST_MDS: begin
                mul_en = 1'b1;
                mul_a  = $signed(MA'(depth));
                mul_b  = MB'(smoothed_reg);
            end
            ST_ML: begin
                mul_en = 1'b1;
                mul_a  = MA'(left_reg);
                mul_b  = gain_reg;
            end
            ST_MR: begin
                mul_en = 1'b1;
                mul_a  = MA'(right_reg);
                mul_b  = gain_reg;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next        = state_reg;
        phase_step_next   = phase_step_reg;
        smooth_coeff_next = smooth_coeff_reg;
        mod_depth_next    = mod_depth_reg;
        mod_offset_next   = mod_offset_reg;
        wave_shape_next   = wave_shape_reg;
        phase_acc_next    = phase_acc_reg;
        smoothed_next     = smoothed_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        w_next            = w_reg;
        acc_next          = acc_reg;
        gain_next         = gain_reg;
        left_res_next     = left_res_reg;
        left_out_next     = left_out_reg;
        right_out_next    = right_out_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;

        if (cfg_we) begin
            case (cfg_index)
                ltg_pkg::REG_PHASE_STEP:   phase_step_next   = PB'(cfg_data);
                ltg_pkg::REG_SMOOTH_COEFF: smooth_coeff_next = cfg_data[15:0];
                ltg_pkg::REG_MOD_DEPTH:    mod_depth_next    = cfg_data[15:0];
                ltg_pkg::REG_MOD_OFFSET:   mod_offset_next   = $signed(cfg_data[15:0]);
                ltg_pkg::REG_WAVE_SHAPE:   wave_shape_next   = cfg_data[1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    left_next  = $signed(s_tdata[SB-1:0]);
                    right_next = $signed(s_tdata[2*SB-1:SB]);
                    state_next = ST_MCM;
                end
            end
            ST_MCM: begin
                w_next     = wave;
                state_next = ST_MCW;
            end
            ST_MCW: begin
                acc_next       = ACCW'(prod) + 36'sd32768;
                phase_acc_next = phase_acc_reg + phase_step_reg;
                state_next     = ST_SMOOTH;
            end
            ST_SMOOTH: begin
                smoothed_next = $signed(acc_sum[32:16]);
                state_next    = ST_MDS;
            end
            ST_MDS: begin
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                gain_next  = MB'(wet_cl + ONE_Q30);
                state_next = ST_ML;
            end
            ST_ML: begin
                state_next = ST_MR;
            end
            ST_MR: begin
                left_res_next = sat_val;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    left_out_next  = left_res_reg;
                    right_out_next = sat_val;
                    m_tvalid_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        left_reg      <= left_next;
        right_reg     <= right_next;
        w_reg         <= w_next;
        acc_reg       <= acc_next;
        gain_reg      <= gain_next;
        left_res_reg  <= left_res_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            phase_step_reg   <= PB'(ltg_pkg::PHASE_STEP_RESET);
            smooth_coeff_reg <= ltg_pkg::SMOOTH_COEFF_RESET;
            mod_depth_reg    <= ltg_pkg::MOD_DEPTH_RESET;
            mod_offset_reg   <= $signed(ltg_pkg::MOD_OFFSET_RESET);
            wave_shape_reg   <= ltg_pkg::SHAPE_SINE;
            phase_acc_reg    <= '0;
            smoothed_reg     <= '0;
        end else begin
            state_reg        <= state_next;
            m_tvalid_reg     <= m_tvalid_next;
            phase_step_reg   <= phase_step_next;
            smooth_coeff_reg <= smooth_coeff_next;
            mod_depth_reg    <= mod_depth_next;
            mod_offset_reg   <= mod_offset_next;
            wave_shape_reg   <= wave_shape_next;
            phase_acc_reg    <= phase_acc_next;
            smoothed_reg     <= smoothed_next;
        end
    end

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ltg_pkg::TDATA_W'({right_out_reg, left_out_reg});

    `LTG_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg == ST_MCM)
    `LTG_ASSERT(a_valid_from_out, $rose(m_tvalid) |-> $past(state_reg) == ST_OUT)
    `LTG_ASSERT(a_smoothed_range, smoothed_reg >= -17'sd32768 && smoothed_reg <= 17'sd32767)
    `LTG_ASSERT(a_gain_range, (state_reg == ST_ML) |-> (gain_reg >= 0 && gain_reg <= 33'sh080000000))

endmodule
`default_nettype wire
